FILE: sv/base64_stream_encoder_macros.svh
// Assertion macros shared by the base64 stream encoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
    else $error("b64e assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B64E_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
    else $error("b64e assertion failed");

`endif

FILE: sv/b64e_pkg.sv
// Types, constants and the alphabet function of the base64 stream encoder.
// Depends on nothing; imported by every module of the encoder.
`timescale 1ns / 1ps
package b64e_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_item_t;

  // One gathered group: up to three bytes, how many are real, and end of message
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] n_bytes;
    logic       last;
  } grp_t;

  localparam logic [1:0] NB_ONE   = 2'd1;
  localparam logic [1:0] NB_TWO   = 2'd2;
  localparam logic [1:0] NB_THREE = 2'd3;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  localparam logic [5:0] SYM_LOWER_START = 6'd26;
  localparam logic [5:0] SYM_DIGIT_START = 6'd52;
  localparam logic [5:0] SYM_PLUS        = 6'd62;

  // Map a 6-bit symbol to its ASCII character
  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] c;
    v8 = {2'b00, v};
    if (v < SYM_LOWER_START) begin
      c = CHAR_UPPER_A + v8;
    end else if (v < SYM_DIGIT_START) begin
      c = CHAR_LOWER_A + v8 - {2'b00, SYM_LOWER_START};
    end else if (v < SYM_PLUS) begin
      c = CHAR_DIGIT_0 + v8 - {2'b00, SYM_DIGIT_START};
    end else if (v == SYM_PLUS) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

FILE: sv/b64e_front.sv
// Front end: accepts bytes, holds a partial group and pushes finished groups.
// Depends on b64e_pkg.
`timescale 1ns / 1ps
module b64e_front
  import b64e_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_item_t in_item,
  output logic     push,
  output grp_t     push_grp
);

  localparam logic [1:0] PHASE_EMPTY = 2'd0;
  localparam logic [1:0] PHASE_ONE   = 2'd1;
  localparam logic [1:0] PHASE_TWO   = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;

  always_comb begin
    push      = 1'b0;
    push_grp  = '0;
    phase_nxt = phase_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    if (accept) begin
      case (phase_r)
        PHASE_TWO: begin
          push      = 1'b1;
          push_grp  = '{byte0: held0_r, byte1: held1_r, byte2: in_item.data_byte,
                        n_bytes: NB_THREE, last: in_item.last_byte};
          phase_nxt = PHASE_EMPTY;
        end
        PHASE_ONE: begin
          if (in_item.last_byte) begin
            push      = 1'b1;
            push_grp  = '{byte0: held0_r, byte1: in_item.data_byte, byte2: 8'h00,
                          n_bytes: NB_TWO, last: 1'b1};
            phase_nxt = PHASE_EMPTY;
          end else begin
            held1_nxt = in_item.data_byte;
            phase_nxt = PHASE_TWO;
          end
        end
        default: begin
          // empty phase, and the unused code treated the same
          if (in_item.last_byte) begin
            push      = 1'b1;
            push_grp  = '{byte0: in_item.data_byte, byte1: 8'h00, byte2: 8'h00,
                          n_bytes: NB_ONE, last: 1'b1};
            phase_nxt = PHASE_EMPTY;
          end else begin
            held0_nxt = in_item.data_byte;
            phase_nxt = PHASE_ONE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_EMPTY;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
  end

endmodule

FILE: sv/b64e_queue.sv
// Short group queue between front and back end.
// Depends on b64e_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "base64_stream_encoder_macros.svh"
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_grp,
  input  logic pop,
  output logic not_empty,
  output logic full,
  output grp_t head_grp
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  grp_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_FULL);
  assign head_grp  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

  `B64E_ASSERT_NOW(a_q_no_overflow, clk, rst_n, push, !full || pop)
  `B64E_ASSERT_NOW(a_q_no_underflow, clk, rst_n, pop, not_empty)
  `B64E_ASSERT_NEXT(a_q_count_hold, clk, rst_n, !push && !pop, count_r == $past(count_r))

endmodule

FILE: sv/b64e_back.sv
// Back end: turns one queued group into four characters, one per cycle unless stalled,
// through a registered output stage. Depends on b64e_pkg and the macro header.
`timescale 1ns / 1ps
`include "base64_stream_encoder_macros.svh"
module b64e_back
  import b64e_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_not_empty,
  input  grp_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [1:0] SLOT_S0 = 2'd0;
  localparam logic [1:0] SLOT_S1 = 2'd1;
  localparam logic [1:0] SLOT_S2 = 2'd2;
  localparam logic [1:0] SLOT_S3 = 2'd3;

  grp_t       cur_r, cur_nxt;
  logic       have_grp_r, have_grp_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r, out_nxt;
  logic       load_out;
  logic [7:0] slot_char;

  assign load_out = !out_valid_r || !out_stall;

  always_comb begin
    case (idx_r)
      SLOT_S0: slot_char = b64_sym(cur_r.byte0[7:2]);
      SLOT_S1: slot_char = b64_sym({cur_r.byte0[1:0], cur_r.byte1[7:4]});
      SLOT_S2: slot_char = (cur_r.n_bytes != NB_ONE)
                           ? b64_sym({cur_r.byte1[3:0], cur_r.byte2[7:6]}) : CHAR_PAD;
      SLOT_S3: slot_char = (cur_r.n_bytes == NB_THREE)
                           ? b64_sym(cur_r.byte2[5:0]) : CHAR_PAD;
      default: slot_char = CHAR_PAD;
    endcase
  end

  always_comb begin
    cur_nxt       = cur_r;
    have_grp_nxt  = have_grp_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    if (load_out) begin
      out_valid_nxt = have_grp_r;
      if (have_grp_r) begin
        out_nxt = '{out_char: slot_char, out_last: cur_r.last && (idx_r == SLOT_S3)};
        idx_nxt = idx_r + 1'b1;
        if (idx_r == SLOT_S3) begin
          have_grp_nxt = 1'b0;
        end
      end
    end
    // refill the group register when it is free or emptying this cycle
    if (q_not_empty && (!have_grp_r || (load_out && idx_r == SLOT_S3))) begin
      q_pop        = 1'b1;
      cur_nxt      = q_head;
      have_grp_nxt = 1'b1;
      idx_nxt      = SLOT_S0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_grp_r  <= 1'b0;
      idx_r       <= SLOT_S0;
      out_valid_r <= 1'b0;
    end else begin
      have_grp_r  <= have_grp_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `B64E_ASSERT_NOW(a_bk_grp_nonempty, clk, rst_n, have_grp_r, cur_r.n_bytes != 2'd0)
  `B64E_ASSERT_NEXT(a_bk_emit, clk, rst_n, have_grp_r && load_out, out_valid_r)
  `B64E_ASSERT_NOW(a_bk_last_at_end, clk, rst_n, out_valid_r && out_r.out_last, !have_grp_r || idx_r == SLOT_S0)

endmodule

FILE: sv/base64_stream_encoder.sv
// Top level of the streaming base64 encoder (standard alphabet, '=' padded).
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in_     | input     | in_valid/in_stall  | in_data  : data_byte, last_byte
//   out_    | output    | out_valid/out_stall| out_data : out_char, out_last
//
// The front end takes one byte per cycle and stalls only while the group queue is full.
// The back end emits one character per cycle while out_stall is low, so a full group
// of three bytes becomes four characters, and a flushed partial group of one or two
// bytes also becomes four characters, padded with '='.
// A finished group passes the queue, then the group register, then the output register.
// Reset is synchronous and active low; it clears the phase, queue and output valid.
// A stalled output holds its character while the queue keeps absorbing groups until full.
`timescale 1ns / 1ps
module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic in_accept;
  logic q_push;
  grp_t q_push_grp;
  logic q_pop;
  logic q_not_empty;
  logic q_full;
  grp_t q_head;

  // hold the input off while no queue slot is free for a finished group
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .in_item  (in_data),
    .push     (q_push),
    .push_grp (q_push_grp)
  );

  b64e_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_grp  (q_push_grp),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .full      (q_full),
    .head_grp  (q_head)
  );

  // advance one character per cycle whenever the output stage frees up
  b64e_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
